/* sv/mcoc_pkg.sv */
// -----------------------------------------------------------------------------
// mcoc_pkg: shared types and constants for the matrix chain order cost block
// Sizes of the chain store and cost table, the sequencer states and the
// control word of the shared arithmetic unit.
// -----------------------------------------------------------------------------
`default_nettype none

package mcoc_pkg;

  localparam int MAX_MATRICES = 128;
  localparam int DIM_BITS     = 8;
  localparam int COST_W       = 32;
  localparam int IN_W         = 8;

  // Matrix index 0..MAX_MATRICES-1, count and dimension address 0..MAX_MATRICES
  localparam int IDX_W   = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int CNT_W   = $clog2(MAX_MATRICES + 1);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int MUL_X_W = 2 * DIM_BITS;
  localparam int PROD_W  = 3 * DIM_BITS;
  localparam int SUM_W   = ((PROD_W > COST_W) ? PROD_W : COST_W) + 2;

  typedef logic [DIM_BITS-1:0] dim_t;
  typedef logic [COST_W-1:0]   cost_t;

  localparam cost_t COST_MAX = '1;

  typedef enum logic [3:0] {
    ST_LOAD,   // take chain items
    ST_FIX,    // store the final column count
    ST_IV_A,   // read left dimension of the interval
    ST_IV_C,   // read right dimension of the interval
    ST_IV_M,   // form the outer dimension product
    ST_SRD,    // read subchain costs and split dimension
    ST_SMUL,   // multiply by split dimension
    ST_SACC,   // add, saturate, keep minimum
    ST_EMIT    // hand the result to the output register
  } state_t;

  typedef struct packed {
    logic init_best;
    logic clear_best;
    logic load_dadc;
    logic load_prod;
    logic acc;
  } alu_ctrl_t;

endpackage

`default_nettype wire

/* sv/mcoc_alu.sv */
// -----------------------------------------------------------------------------
// mcoc_alu: shared multiply / saturating add / minimum unit
// One multiplier forms the outer dimension product per interval and the
// split product per split point; the adder sums two subchain costs with it,
// clamps to the cost range and keeps the running minimum.
// -----------------------------------------------------------------------------
`default_nettype none

module mcoc_alu (
  input  wire                    clk,
  input  wire mcoc_pkg::alu_ctrl_t ctrl,
  input  wire mcoc_pkg::dim_t    da,
  input  wire mcoc_pkg::dim_t    dq,
  input  wire mcoc_pkg::cost_t   c1,
  input  wire mcoc_pkg::cost_t   c2,
  output mcoc_pkg::cost_t        best,
  output mcoc_pkg::cost_t        best_new
);
  import mcoc_pkg::*;

  logic [MUL_X_W-1:0] dadc;
  logic [PROD_W-1:0]  prod;
  logic [MUL_X_W-1:0] mul_x;
  logic [PROD_W-1:0]  mul_r;
  logic [SUM_W-1:0]   sum;
  cost_t              sat;

  assign mul_x = ctrl.load_dadc ? MUL_X_W'(da) : dadc;
  assign mul_r = {{DIM_BITS{1'b0}}, mul_x} * {{MUL_X_W{1'b0}}, dq};

  assign sum      = SUM_W'(c1) + SUM_W'(c2) + SUM_W'(prod);
  assign sat      = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
  assign best_new = (sat < best) ? sat : best;

  always_ff @(posedge clk) begin
    if (ctrl.load_dadc) begin
      dadc <= mul_r[MUL_X_W-1:0];
    end
    if (ctrl.load_prod) begin
      prod <= mul_r;
    end
    if (ctrl.init_best) begin
      best <= COST_MAX;
    end else if (ctrl.clear_best) begin
      best <= '0;
    end else if (ctrl.acc) begin
      best <= best_new;
    end
  end

endmodule

`default_nettype wire

/* sv/matrix_chain_order_cost.sv */
// -----------------------------------------------------------------------------
// matrix_chain_order_cost: minimum scalar multiplication count of a chain
// Loads row/column counts of a matrix chain, then fills the interval cost
// table by the interval recurrence on one shared arithmetic unit.
// -----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)          | tuser | tlast
//  s_axis   | in  | rows[7:0], cols[15:8]       | -     | last matrix of chain
//  m_axis   | out | min_cost[31:0]              | -     | -
//
//  Loading takes one transfer per cycle; the column count of the final matrix
//  is stored in the cycle after the tlast transfer.
//  The table fill runs ST_IV_A, ST_IV_C, ST_IV_M once per interval and ST_SRD,
//  ST_SMUL, ST_SACC once per split point, an order set by the single multiplier
//  and the two-read cost memory; a single matrix skips it.
//  s_axis_tready is low from the tlast transfer until the result is in the
//  output register; a result not yet taken stalls only the next result.
//  rst is synchronous; the memories are not cleared.
// -----------------------------------------------------------------------------
`default_nettype none

module matrix_chain_order_cost (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // rows[7:0], cols[15:8]
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata    // min_cost[31:0]
);
  import mcoc_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  len;
  logic [IDX_W-1:0]  a, b, s;
  dim_t              last_col;
  dim_t              da;
  alu_ctrl_t         alu_ctrl;
  cost_t             best, best_new;

  // dimension store
  dim_t              dim_mem [MAX_MATRICES+1];
  dim_t              dim_q;
  logic [CNT_W-1:0]  dim_raddr;
  logic [CNT_W-1:0]  dim_waddr;
  dim_t              dim_wdata;
  logic              dim_we;

  // interval cost table
  cost_t             cost_mem [MAX_MATRICES*MAX_MATRICES];
  cost_t             cost_q1, cost_q2;
  logic              zero1, zero2;
  cost_t             c1, c2;

  logic              in_xfer;
  logic              split_end;
  logic              iv_more;
  logic              chain_done;
  dim_t              rows_in, cols_in;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign rows_in    = dim_t'(s_axis_tdata[IN_W-1:0]);
  assign cols_in    = dim_t'(s_axis_tdata[2*IN_W-1:IN_W]);
  assign split_end  = (s == b - IDX_W'(1));
  assign iv_more    = (CNT_W'(b) + CNT_W'(1)) < count;
  assign chain_done = (len == count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_xfer && s_axis_tlast) state_next = ST_FIX;
      ST_FIX:  state_next = (count == CNT_W'(1)) ? ST_EMIT : ST_IV_A;
      ST_IV_A: state_next = ST_IV_C;
      ST_IV_C: state_next = ST_IV_M;
      ST_IV_M: state_next = ST_SRD;
      ST_SRD:  state_next = ST_SMUL;
      ST_SMUL: state_next = ST_SACC;
      ST_SACC: begin
        if (!split_end) begin
          state_next = ST_SRD;
        end else if (iv_more || !chain_done) begin
          state_next = ST_IV_A;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: if (!m_axis_tvalid || m_axis_tready) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    alu_ctrl      = '0;
    dim_raddr     = CNT_W'(a);
    dim_we        = 1'b0;
    dim_waddr     = count;
    dim_wdata     = rows_in;
    unique case (state)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        dim_we        = in_xfer && (count < CNT_W'(MAX_MATRICES));
      end
      ST_FIX: begin
        dim_we             = 1'b1;
        dim_wdata          = last_col;
        alu_ctrl.clear_best = 1'b1;
      end
      ST_IV_A: begin
        dim_raddr          = CNT_W'(a);
        alu_ctrl.init_best = 1'b1;
      end
      ST_IV_C: dim_raddr = CNT_W'(b) + CNT_W'(1);
      ST_IV_M: alu_ctrl.load_dadc = 1'b1;
      ST_SRD:  dim_raddr = CNT_W'(s) + CNT_W'(1);
      ST_SMUL: alu_ctrl.load_prod = 1'b1;
      ST_SACC: alu_ctrl.acc = 1'b1;
      ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // chain length and interval counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (state == ST_LOAD && in_xfer && count < CNT_W'(MAX_MATRICES)) begin
        count    <= count + CNT_W'(1);
        last_col <= cols_in;
      end
      if (state == ST_EMIT && state_next == ST_LOAD) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_FIX: begin
        len <= CNT_W'(2);
        a   <= '0;
        b   <= IDX_W'(1);
      end
      ST_IV_C: da <= dim_q;
      ST_IV_M: s  <= a;
      ST_SACC: begin
        if (!split_end) begin
          s <= s + IDX_W'(1);
        end else if (iv_more) begin
          a <= a + IDX_W'(1);
          b <= b + IDX_W'(1);
        end else begin
          // next interval length starts at the left end
          len <= len + CNT_W'(1);
          a   <= '0;
          b   <= len[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // dimension store, one write and one registered read
  always_ff @(posedge clk) begin
    if (dim_we) begin
      dim_mem[dim_waddr] <= dim_wdata;
    end
    dim_q <= dim_mem[dim_raddr];
  end

  // cost table, two registered reads; the diagonal reads as zero
  always_ff @(posedge clk) begin
    if (state == ST_SACC && split_end) begin
      cost_mem[{a, b}] <= best_new;
    end
    if (state == ST_SRD) begin
      cost_q1 <= cost_mem[{a, s}];
      cost_q2 <= cost_mem[{s + IDX_W'(1), b}];
      zero1   <= (s == a);
      zero2   <= (s + IDX_W'(1) == b);
    end
  end

  assign c1 = zero1 ? '0 : cost_q1;
  assign c2 = zero2 ? '0 : cost_q2;

  mcoc_alu u_alu (
    .clk      (clk),
    .ctrl     (alu_ctrl),
    .da       (da),
    .dq       (dim_q),
    .c1       (c1),
    .c2       (c2),
    .best     (best),
    .best_new (best_new)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= 32'(best);
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_MATRICES))
    else $error("chain count beyond store depth");

  a_split_inside: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRD || state == ST_SMUL || state == ST_SACC) |-> (s >= a && s < b))
    else $error("split point outside interval");

  a_interval_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IV_A) |-> (CNT_W'(b) - CNT_W'(a) + CNT_W'(1) == len && len <= count))
    else $error("interval bounds disagree with length");

  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken while chain cost is computed");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb: stream-level bench for matrix_chain_order_cost
// Feeds matrix chains (row/column counts, tlast on the final matrix), works out
// the minimum multiplication count of each chain with an interval table of its
// own and checks every min_cost transfer against it, with random idle gaps on
// the input stream and random back-pressure on the result stream.
// -----------------------------------------------------------------------------

module tb;
  import mcoc_pkg::*;

  typedef struct {
    logic [IN_W-1:0] rows;
    logic [IN_W-1:0] cols;
    logic            last;
  } mat_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // rows[7:0], cols[15:8]
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // min_cost[31:0]

  mat_item_t   pending_mats[$];
  cost_t       cost_expected[$];

  // Own copy of the chain store and interval table
  dim_t        chain_dims[0:MAX_MATRICES];
  cost_t       span_cost[0:MAX_MATRICES-1][0:MAX_MATRICES-1];
  int unsigned held = 0;

  int unsigned src_gap = 0;
  int unsigned sink_wait = 0;
  logic        calm = 1'b0;
  int unsigned errors = 0;
  int unsigned mats_sent = 0;
  int unsigned chains_closed = 0;
  int unsigned dropped_mats = 0;
  int unsigned results_seen = 0;
  int unsigned longest_held = 0;
  int unsigned random_fed = 0;

  matrix_chain_order_cost dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic cost_t chain_min_cost(int n);
    longint unsigned best;
    longint unsigned trial;
    int a;
    int b;
    int s;
    int len;
    for (a = 0; a < n; a++) span_cost[a][a] = '0;
    for (len = 2; len <= n; len++) begin
      for (a = 0; a + len <= n; a++) begin
        b = a + len - 1;
        best = 64'(COST_MAX);
        for (s = a; s < b; s++) begin
          trial = 64'(span_cost[a][s]) + 64'(span_cost[s+1][b])
                + 64'(chain_dims[a]) * 64'(chain_dims[s+1]) * 64'(chain_dims[b+1]);
          if (trial < best) best = trial;
        end
        span_cost[a][b] = cost_t'(best);
      end
    end
    return span_cost[0][n-1];
  endfunction

  task automatic absorb_matrix(logic [IN_W-1:0] r, logic [IN_W-1:0] c, logic fin);
    // The next matrix's rows overwrite this one's cols; items past capacity drop
    if (held < MAX_MATRICES) begin
      chain_dims[held]   = dim_t'(r);
      chain_dims[held+1] = dim_t'(c);
      held++;
    end else begin
      dropped_mats++;
    end
    if (fin) begin
      cost_expected.push_back(chain_min_cost(held));
      if (held > longest_held) longest_held = held;
      chains_closed++;
      held = 0;
    end
  endtask

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [IN_W-1:0] rand_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 8) return '1;
    if (r < 40) return IN_W'($urandom_range(1, 16));
    return IN_W'($urandom_range(1, 255));
  endfunction

  task automatic queue_matrix(logic [IN_W-1:0] r, logic [IN_W-1:0] c, logic fin);
    mat_item_t it;
    it.rows = r;
    it.cols = c;
    it.last = fin;
    pending_mats.push_back(it);
  endtask

  // Flip between quiet stretches and gappy stretches now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 399) == 0) calm <= ~calm;
  end

  always @(posedge clk) begin : source_drive
    mat_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_matrix(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast);
        mats_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_mats.size() > 0) begin
          nxt = pending_mats.pop_front();
          s_axis_tdata  <= {nxt.cols, nxt.rows};
          s_axis_tlast  <= nxt.last;
          s_axis_tvalid <= 1'b1;
          src_gap <= pick_idle();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    cost_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (cost_expected.size() == 0) begin
          $display("%0t: min_cost %0d arrived with nothing expected", $time, m_axis_tdata);
          errors++;
        end else begin
          want = cost_expected.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: min_cost mismatch, expected %0d got %0d",
                     $time, want, m_axis_tdata);
            errors++;
          end
        end
      end
      if (sink_wait > 0) begin
        sink_wait <= sink_wait - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        sink_wait <= pick_idle();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [IN_W-1:0] link[0:MAX_MATRICES+3];
    int n;
    int k;
    bit tidy;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // single matrices cost nothing
    queue_matrix(8'd1, 8'd1, 1'b1);
    queue_matrix(8'd255, 8'd255, 1'b1);
    // largest single product
    queue_matrix(8'd255, 8'd255, 1'b0);
    queue_matrix(8'd255, 8'd255, 1'b1);
    // zero dimensions wipe out products
    queue_matrix(8'd0, 8'd5, 1'b0);
    queue_matrix(8'd5, 8'd7, 1'b0);
    queue_matrix(8'd7, 8'd3, 1'b1);
    queue_matrix(8'd4, 8'd0, 1'b0);
    queue_matrix(8'd0, 8'd9, 1'b1);
    // mismatched neighbours: rows of the next matrix win
    queue_matrix(8'd3, 8'd4, 1'b0);
    queue_matrix(8'd9, 8'd2, 1'b0);
    queue_matrix(8'd2, 8'd6, 1'b1);
    // alternating extremes
    queue_matrix(8'd1, 8'd255, 1'b0);
    queue_matrix(8'd255, 8'd1, 1'b0);
    queue_matrix(8'd1, 8'd255, 1'b0);
    queue_matrix(8'd255, 8'd1, 1'b0);
    queue_matrix(8'd1, 8'd128, 1'b0);
    queue_matrix(8'd128, 8'd1, 1'b1);
    queue_matrix(8'hAA, 8'h55, 1'b0);
    queue_matrix(8'h55, 8'hAA, 1'b1);

    // Overlong chain: fill capacity, then items that must not be stored
    for (k = 0; k <= MAX_MATRICES + 3; k++) link[k] = rand_dim();
    for (k = 0; k < MAX_MATRICES + 3; k++)
      queue_matrix(link[k], link[k+1], k == MAX_MATRICES + 2);

    while (random_fed < 2000) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      tidy = ($urandom_range(0, 4) != 0);
      for (k = 0; k <= n; k++) link[k] = rand_dim();
      for (k = 0; k < n; k++) begin
        if (tidy) queue_matrix(link[k], link[k+1], k == n - 1);
        else      queue_matrix(rand_dim(), rand_dim(), k == n - 1);
      end
      random_fed += n;
    end

    while (pending_mats.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (cost_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d matrices in %0d chains, %0d past capacity dropped, longest %0d held.",
             mats_sent, chains_closed, dropped_mats, longest_held);
    $display("Checked %0d chain costs with %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("matrix_chain_order_cost verification clean");
    end else begin
      $display("matrix_chain_order_cost verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("Timed out with %0d chain costs outstanding.", cost_expected.size());
    $display("matrix_chain_order_cost verification failed");
    $finish;
  end

endmodule

/* sim.f */
sv/mcoc_pkg.sv
sv/mcoc_alu.sv
sv/matrix_chain_order_cost.sv
bench/tb.sv
